### hdl/hefp_pkg.sv
// ----------------------------------------------------------------------------
// Heater exchange frame parser package
// Shared types, protocol constants and the byte-wide CRC-16 update.
// ----------------------------------------------------------------------------
package hefp_pkg;

   // Frame layout.
   localparam logic [5:0] EXCHANGE_LEN = 6'd48;
   localparam logic [5:0] CAPTURE_START = 6'd2;
   localparam logic [5:0] CRC_SPAN = 6'd22;
   localparam logic [5:0] CRC1_HI_IDX = 6'd22;
   localparam logic [5:0] CRC1_LO_IDX = 6'd23;
   localparam logic [5:0] CRC2_SPAN_END = 6'd46;
   localparam logic [5:0] CRC2_HI_IDX = 6'd46;

   // Byte offsets of captured and checked bytes.
   localparam logic [5:0] OFS_SET_VALUE = 6'd4;
   localparam logic [5:0] OFS_HDR2 = 6'd24;
   localparam logic [5:0] OFS_SYNC2 = 6'd25;
   localparam logic [5:0] OFS_RUN_STATE = 6'd26;
   localparam logic [5:0] OFS_ACTIVE_ERR = 6'd27;
   localparam logic [5:0] OFS_FAN_HI = 6'd30;
   localparam logic [5:0] OFS_FAN_LO = 6'd31;
   localparam logic [5:0] OFS_CHAMBER_HI = 6'd34;
   localparam logic [5:0] OFS_CHAMBER_LO = 6'd35;
   localparam logic [5:0] OFS_PUMP = 6'd40;
   localparam logic [5:0] OFS_FAULT = 6'd41;
   localparam logic [5:0] OFS_FIXED_A = 6'd44;
   localparam logic [5:0] OFS_FIXED_B = 6'd45;

   // Byte values.
   localparam logic [7:0] HDR_CTRL = 8'h76;
   localparam logic [7:0] HDR_ALT = 8'h78;
   localparam logic [7:0] SYNC_BYTE = 8'h16;
   localparam logic [7:0] FIXED_A_VAL = 8'd100;
   localparam logic [7:0] FIXED_B_VAL = 8'd0;

   // Run state limits.
   localparam logic [7:0] RUN_STATE_MAX = 8'd8;
   localparam logic [3:0] POWER_ON_MIN = 4'd1;
   localparam logic [3:0] POWER_ON_MAX = 4'd5;

   // CRC-16 (Modbus) constants.
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   // Configuration reset value.
   localparam logic [15:0] IDLE_GAP_RESET = 16'd100;

   // One received byte with its preceding idle time.
   typedef struct packed {
      logic [15:0] gap_ms;
      logic [7:0]  rx_byte;
   } item_type;

   // One result transaction.
   typedef struct packed {
      logic        exchange_valid;
      logic        exchange_rejected;
      logic        command_window;
      logic [7:0]  set_value;
      logic [3:0]  run_state;
      logic [7:0]  active_error;
      logic [7:0]  fault_code;
      logic        power_on;
      logic [7:0]  pump_rate;
      logic [15:0] blower_speed;
      logic [15:0] combustion_temp;
   } result_type;

   // Reflected CRC-16 update over one byte.
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

### hdl/hefp_in_reg.sv
// ----------------------------------------------------------------------------
// Input register
// Holds one accepted byte transaction until the parser core consumes it.
// ----------------------------------------------------------------------------
module hefp_in_reg import hefp_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     load,
   input  item_type load_item,
   input  logic     consume,
   output logic     item_valid,
   output item_type item
);

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;

   // A new transaction replaces the consumed one; otherwise a consume drains the slot.
   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (consume) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset.
   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= load_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

### hdl/hefp_core.sv
// ----------------------------------------------------------------------------
// Parser core
// Gap detection, command window count, header hunt, frame capture with CRC
// and fixed-byte checks, and telemetry extraction for one byte per cycle while step is high.
// ----------------------------------------------------------------------------
module hefp_core import hefp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   input  logic        step,
   input  item_type    item,
   output logic        has_result,
   output result_type  result
);

   // Configuration and control state.
   logic [15:0] idle_gap_ff;
   logic        header_seen_ff, header_seen_in;
   logic        capturing_ff, capturing_in;
   logic [5:0]  byte_index_ff, byte_index_in;
   logic [15:0] crc_ff, crc_in;
   logic        first_ok_ff, first_ok_in;
   logic        fixed_ok_ff, fixed_ok_in;
   logic [3:0]  held_state_ff, held_state_in;
   logic        win_open_ff, win_open_in;
   logic [5:0]  win_count_ff, win_count_in;

   // Captured telemetry bytes.
   logic [7:0]  set_ff, run_raw_ff, active_ff, fault_ff, pump_ff;
   logic [15:0] fan_ff, chamber_ff;

   logic [7:0]  b;
   logic        gap_hit;
   logic [5:0]  cap_idx;
   logic [5:0]  idx_next;
   logic [15:0] crc_from_reg;
   logic [15:0] crc_from_init;
   logic        win_hit;
   logic        done;
   logic        valid;

   assign b             = item.rx_byte;
   assign gap_hit       = item.gap_ms > idle_gap_ff;
   assign crc_from_reg  = crc16_byte(crc_ff, b);
   assign crc_from_init = crc16_byte(CRC_INIT, b);
   assign cap_idx       = (byte_index_ff < CAPTURE_START || byte_index_ff >= EXCHANGE_LEN) ?
                          CAPTURE_START : byte_index_ff;
   assign idx_next      = cap_idx + 6'd1;

   // Next-state logic for one byte.
   always_comb begin
      header_seen_in = header_seen_ff;
      capturing_in   = capturing_ff;
      byte_index_in  = byte_index_ff;
      crc_in         = crc_ff;
      first_ok_in    = first_ok_ff;
      fixed_ok_in    = fixed_ok_ff;
      held_state_in  = held_state_ff;
      win_open_in    = win_open_ff;
      win_count_in   = win_count_ff;
      win_hit        = 1'b0;
      done           = 1'b0;
      valid          = 1'b0;

      // A long idle gap drops any partial capture and opens the window.
      if (gap_hit) begin
         capturing_in   = 1'b0;
         header_seen_in = 1'b0;
         byte_index_in  = '0;
         win_open_in    = 1'b1;
         win_count_in   = '0;
      end

      // Count bytes since the gap; the 48th one closes the window.
      if (win_open_in) begin
         win_count_in = win_count_in + 6'd1;
         if (win_count_in == EXCHANGE_LEN) begin
            win_open_in  = 1'b0;
            win_count_in = '0;
            win_hit      = 1'b1;
         end
      end

      if (!capturing_in) begin
         // Header hunt.
         if (header_seen_in && b == SYNC_BYTE) begin
            crc_in         = crc_from_reg;
            byte_index_in  = CAPTURE_START;
            capturing_in   = 1'b1;
            header_seen_in = 1'b0;
            first_ok_in    = 1'b0;
            fixed_ok_in    = 1'b1;
         end else if (b == HDR_CTRL || b == HDR_ALT) begin
            crc_in         = crc_from_init;
            header_seen_in = 1'b1;
         end else begin
            header_seen_in = 1'b0;
         end
      end else begin
         // CRC accumulation and trailer checks for both halves.
         if (cap_idx < CRC_SPAN) begin
            crc_in = crc_from_reg;
         end else if (cap_idx == CRC1_HI_IDX) begin
            first_ok_in = (b == crc_ff[15:8]);
         end else if (cap_idx == CRC1_LO_IDX) begin
            first_ok_in = first_ok_ff && (b == crc_ff[7:0]);
            crc_in      = CRC_INIT;
         end else if (cap_idx < CRC2_SPAN_END) begin
            crc_in = crc_from_reg;
         end else if (cap_idx == CRC2_HI_IDX) begin
            if (b != crc_ff[15:8]) begin
               fixed_ok_in = 1'b0;
            end
         end else begin
            if (b != crc_ff[7:0]) begin
               fixed_ok_in = 1'b0;
            end
         end

         // Fixed-byte checks.
         case (cap_idx)
            OFS_HDR2: begin
               if (b != HDR_CTRL) fixed_ok_in = 1'b0;
            end
            OFS_SYNC2: begin
               if (b != SYNC_BYTE) fixed_ok_in = 1'b0;
            end
            OFS_FIXED_A: begin
               if (b != FIXED_A_VAL) fixed_ok_in = 1'b0;
            end
            OFS_FIXED_B: begin
               if (b != FIXED_B_VAL) fixed_ok_in = 1'b0;
            end
            default: begin
            end
         endcase

         // End of the exchange.
         byte_index_in = idx_next;
         if (idx_next == EXCHANGE_LEN) begin
            capturing_in   = 1'b0;
            byte_index_in  = '0;
            header_seen_in = 1'b0;
            done           = 1'b1;
            valid          = first_ok_in && fixed_ok_in;
            if (valid && run_raw_ff <= RUN_STATE_MAX) begin
               held_state_in = run_raw_ff[3:0];
            end
         end
      end
   end

   // Control state and configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         idle_gap_ff    <= IDLE_GAP_RESET;
         header_seen_ff <= 1'b0;
         capturing_ff   <= 1'b0;
         byte_index_ff  <= '0;
         crc_ff         <= CRC_INIT;
         first_ok_ff    <= 1'b0;
         fixed_ok_ff    <= 1'b0;
         held_state_ff  <= '0;
         win_open_ff    <= 1'b0;
         win_count_ff   <= '0;
      end else begin
         if (csr_wr_en) begin
            idle_gap_ff <= csr_wr_data;
         end
         if (step) begin
            header_seen_ff <= header_seen_in;
            capturing_ff   <= capturing_in;
            byte_index_ff  <= byte_index_in;
            crc_ff         <= crc_in;
            first_ok_ff    <= first_ok_in;
            fixed_ok_ff    <= fixed_ok_in;
            held_state_ff  <= held_state_in;
            win_open_ff    <= win_open_in;
            win_count_ff   <= win_count_in;
         end
      end
   end

   // Telemetry capture at fixed offsets; read only after a full valid frame.
   always_ff @(posedge clock) begin
      if (step && capturing_ff && !gap_hit) begin
         case (cap_idx)
            OFS_SET_VALUE:  set_ff            <= b;
            OFS_RUN_STATE:  run_raw_ff        <= b;
            OFS_ACTIVE_ERR: active_ff         <= b;
            OFS_FAN_HI:     fan_ff[15:8]      <= b;
            OFS_FAN_LO:     fan_ff[7:0]       <= b;
            OFS_CHAMBER_HI: chamber_ff[15:8]  <= b;
            OFS_CHAMBER_LO: chamber_ff[7:0]   <= b;
            OFS_PUMP:       pump_ff           <= b;
            OFS_FAULT:      fault_ff          <= b;
            default: begin
            end
         endcase
      end
   end

   // Result assembly; telemetry reads as zero unless the frame is valid.
   always_comb begin
      has_result               = done || win_hit;
      result.exchange_valid    = valid;
      result.exchange_rejected = done && !valid;
      result.command_window    = win_hit;
      result.run_state         = held_state_in;
      result.power_on          = (held_state_in >= POWER_ON_MIN) &&
                                 (held_state_in <= POWER_ON_MAX);
      result.set_value         = valid ? set_ff : 8'h00;
      result.active_error      = valid ? active_ff : 8'h00;
      result.fault_code        = valid ? fault_ff : 8'h00;
      result.pump_rate         = valid ? pump_ff : 8'h00;
      result.blower_speed      = valid ? fan_ff : 16'h0000;
      result.combustion_temp   = valid ? chamber_ff : 16'h0000;
   end

endmodule

### hdl/hefp_out_reg.sv
// ----------------------------------------------------------------------------
// Result register
// Holds one result transaction until the downstream side takes it.
// ----------------------------------------------------------------------------
module hefp_out_reg import hefp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type load_result,
   input  logic       taken,
   output logic       result_valid,
   output result_type result
);

   logic       valid_ff;
   logic       valid_in;
   result_type result_ff;

   // A new result wins over a drain in the same cycle.
   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (taken) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= load_result;
      end
   end

   assign result_valid = valid_ff;
   assign result       = result_ff;

endmodule

### hdl/heater_exchange_frame_parser_unit.sv
// A byte is registered in the input register and its result, if any, in the result register.
// Throughput: one byte per cycle unless a result waits on the output; the CRC-16 update sets the path.
// A byte that causes no result passes through the core without occupying the output.
// Reset (synchronous, active high) clears hunt, capture and window state, sets the
// idle gap threshold to 100 ms and the held run state to off; captured telemetry
// bytes are not reset.
// ----------------------------------------------------------------------------
// Heater exchange frame parser
// Parses 48-byte heater exchanges from a byte stream and reports telemetry.
// ----------------------------------------------------------------------------
module heater_exchange_frame_parser_unit import hefp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // Configuration write port: idle_gap_ms
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   // Byte channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // rx_byte[7:0], gap_ms[23:8]
   // Result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // set_value[7:0], run_state[11:8], active_error[19:12],
                                    // fault_code[27:20], power_on[28], pump_rate[36:29],
                                    // blower_speed[52:37], combustion_temp[68:53],
                                    // zero[71:69]
   output logic [2:0]  rsp_tuser    // exchange_valid[0], exchange_rejected[1],
                                    // command_window[2]
);

   item_type   req_item;
   item_type   cur_item;
   logic       cur_valid;
   logic       core_has_result;
   result_type core_result;
   result_type rsp_result;
   logic       out_free;
   logic       step;
   logic       req_fire;

   assign req_item.rx_byte = req_tdata[7:0];
   assign req_item.gap_ms  = req_tdata[23:8];

   // Handshake: the core steps when its result, if any, has room.
   assign out_free   = !rsp_tvalid || rsp_tready;
   assign step       = cur_valid && (!core_has_result || out_free);
   assign req_tready = !cur_valid || step;
   assign req_fire   = req_tvalid && req_tready;

   hefp_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (req_fire),
      .load_item  (req_item),
      .consume    (step),
      .item_valid (cur_valid),
      .item       (cur_item)
   );

   hefp_core u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .step        (step),
      .item        (cur_item),
      .has_result  (core_has_result),
      .result      (core_result)
   );

   hefp_out_reg u_out_reg (
      .clock        (clock),
      .reset        (reset),
      .load         (step && core_has_result),
      .load_result  (core_result),
      .taken        (rsp_tready),
      .result_valid (rsp_tvalid),
      .result       (rsp_result)
   );

   // Output packing.
   assign rsp_tuser = {rsp_result.command_window, rsp_result.exchange_rejected,
                       rsp_result.exchange_valid};
   assign rsp_tdata = {3'b000, rsp_result.combustion_temp, rsp_result.blower_speed,
                       rsp_result.pump_rate, rsp_result.power_on, rsp_result.fault_code,
                       rsp_result.active_error, rsp_result.run_state, rsp_result.set_value};

   // Every result transaction carries at least one reason.
   a_result_has_reason: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser != 3'b000))
      else $error("result transaction without a flag");

   // Valid and rejected never appear together.
   a_valid_rejected_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1]))
      else $error("exchange both valid and rejected");

   // A core step with a result shows up on the result channel next cycle.
   a_step_to_output: assert property (@(posedge clock) disable iff (reset)
      (step && core_has_result) |=> rsp_tvalid)
      else $error("result lost between core and output register");

   // Telemetry is zero unless the exchange is valid; run state and power flag always report.
   a_zero_telemetry: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tdata[7:0] == 8'h00 &&
                                         rsp_tdata[27:12] == 16'd0 &&
                                         rsp_tdata[68:29] == 40'd0))
      else $error("telemetry present on a non-valid result");

endmodule

### test/hefp_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Heater exchange frame parser checker
// Watches the byte, result and configuration ports of the parser. It keeps its
// own model of the hunt, capture, CRC and command window logic, predicts each
// result transaction and compares every field of what the block returns.
// ----------------------------------------------------------------------------
module hefp_checker import hefp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [71:0] rsp_tdata,
   input  logic [2:0]  rsp_tuser,
   output int          error_count,
   output int          reports_due,
   output int          good_exchanges,
   output int          rejected_exchanges,
   output int          windows_closed
);

   // Model copy of the configuration and the parser state.
   logic [15:0] gap_limit;
   logic        hunting_sync;
   logic        in_frame;
   logic [5:0]  frame_pos;
   logic [15:0] crc_acc;
   logic        half1_good;
   logic        fixed_good;
   logic [7:0]  set_byte;
   logic [7:0]  state_byte;
   logic [7:0]  pump_byte;
   logic [15:0] fan_word;
   logic [15:0] chamber_word;
   logic [7:0]  active_err_byte;
   logic [7:0]  fault_byte;
   logic [3:0]  held_state;
   logic        win_open;
   logic [5:0]  win_cnt;

   // Result transactions predicted but not yet returned, oldest first.
   result_type  predicted_reports[$];

   // One byte of the reflected Modbus CRC-16.
   function automatic logic [15:0] crc_fold(input logic [15:0] acc, input logic [7:0] d);
      logic [15:0] r;
      r = acc ^ {8'h00, d};
      repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      return r;
   endfunction

   function automatic string show(input result_type r);
      return $sformatf({"valid=%0b rej=%0b win=%0b set=%02h state=%0d aerr=%02h ",
                        "fault=%02h pwr=%0b pump=%02h fan=%04h chamber=%04h"},
                       r.exchange_valid, r.exchange_rejected, r.command_window,
                       r.set_value, r.run_state, r.active_error, r.fault_code,
                       r.power_on, r.pump_rate, r.blower_speed, r.combustion_temp);
   endfunction

   // Folds one captured byte into the CRC checks, fixed-byte checks and telemetry.
   task automatic absorb_byte(input logic [5:0] pos, input logic [7:0] d);
      if (pos < CRC_SPAN) begin
         crc_acc = crc_fold(crc_acc, d);
      end else if (pos == CRC1_HI_IDX) begin
         half1_good = (d == crc_acc[15:8]);
      end else if (pos == CRC1_LO_IDX) begin
         half1_good = half1_good && (d == crc_acc[7:0]);
         crc_acc = CRC_INIT;
      end else if (pos < CRC2_HI_IDX) begin
         crc_acc = crc_fold(crc_acc, d);
      end else if (pos == CRC2_HI_IDX) begin
         if (d != crc_acc[15:8]) fixed_good = 1'b0;
      end else begin
         if (d != crc_acc[7:0]) fixed_good = 1'b0;
      end

      case (pos)
         OFS_SET_VALUE:  set_byte = d;
         OFS_HDR2:       if (d != HDR_CTRL) fixed_good = 1'b0;
         OFS_SYNC2:      if (d != SYNC_BYTE) fixed_good = 1'b0;
         OFS_RUN_STATE:  state_byte = d;
         OFS_ACTIVE_ERR: active_err_byte = d;
         OFS_FAN_HI:     fan_word[15:8] = d;
         OFS_FAN_LO:     fan_word[7:0] = d;
         OFS_CHAMBER_HI: chamber_word[15:8] = d;
         OFS_CHAMBER_LO: chamber_word[7:0] = d;
         OFS_PUMP:       pump_byte = d;
         OFS_FAULT:      fault_byte = d;
         OFS_FIXED_A:    if (d != FIXED_A_VAL) fixed_good = 1'b0;
         OFS_FIXED_B:    if (d != FIXED_B_VAL) fixed_good = 1'b0;
         default: ;
      endcase
   endtask

   // Advances the model by one accepted byte and queues the result it causes.
   task automatic parse_rx_byte(input logic [7:0] d, input logic [15:0] gap);
      logic       win;
      logic       done;
      logic       ok;
      logic [5:0] pos;
      result_type r;
      win = 1'b0;
      done = 1'b0;
      ok = 1'b0;

      // A long idle gap drops any capture and restarts the command window.
      if (gap > gap_limit) begin
         in_frame = 1'b0;
         hunting_sync = 1'b0;
         frame_pos = '0;
         win_open = 1'b1;
         win_cnt = '0;
      end

      if (win_open) begin
         win_cnt = win_cnt + 6'd1;
         if (win_cnt == EXCHANGE_LEN) begin
            win_open = 1'b0;
            win_cnt = '0;
            win = 1'b1;
         end
      end

      // Header hunt, then capture of the remaining exchange bytes.
      if (!in_frame) begin
         if (hunting_sync && d == SYNC_BYTE) begin
            crc_acc = crc_fold(crc_acc, d);
            frame_pos = CAPTURE_START;
            in_frame = 1'b1;
            hunting_sync = 1'b0;
            half1_good = 1'b0;
            fixed_good = 1'b1;
         end else if (d == HDR_CTRL || d == HDR_ALT) begin
            crc_acc = crc_fold(CRC_INIT, d);
            hunting_sync = 1'b1;
         end else begin
            hunting_sync = 1'b0;
         end
      end else begin
         pos = frame_pos;
         if (pos < CAPTURE_START || pos >= EXCHANGE_LEN) pos = CAPTURE_START;
         absorb_byte(pos, d);
         frame_pos = pos + 6'd1;
         if (frame_pos == EXCHANGE_LEN) begin
            in_frame = 1'b0;
            frame_pos = '0;
            hunting_sync = 1'b0;
            done = 1'b1;
            ok = half1_good && fixed_good;
            if (ok && state_byte <= RUN_STATE_MAX) held_state = state_byte[3:0];
         end
      end

      if (done || win) begin
         r = '0;
         r.exchange_valid = ok;
         r.exchange_rejected = done && !ok;
         r.command_window = win;
         r.run_state = held_state;
         r.power_on = (held_state >= POWER_ON_MIN) && (held_state <= POWER_ON_MAX);
         if (ok) begin
            r.set_value = set_byte;
            r.active_error = active_err_byte;
            r.fault_code = fault_byte;
            r.pump_rate = pump_byte;
            r.blower_speed = fan_word;
            r.combustion_temp = chamber_word;
         end
         predicted_reports.push_back(r);
      end
   endtask

   // Compares one returned result transaction with the oldest prediction.
   task automatic check_report();
      result_type got;
      result_type want;
      string      diff;
      got = '0;
      got.exchange_valid = rsp_tuser[0];
      got.exchange_rejected = rsp_tuser[1];
      got.command_window = rsp_tuser[2];
      got.set_value = rsp_tdata[7:0];
      got.run_state = rsp_tdata[11:8];
      got.active_error = rsp_tdata[19:12];
      got.fault_code = rsp_tdata[27:20];
      got.power_on = rsp_tdata[28];
      got.pump_rate = rsp_tdata[36:29];
      got.blower_speed = rsp_tdata[52:37];
      got.combustion_temp = rsp_tdata[68:53];

      good_exchanges += got.exchange_valid;
      rejected_exchanges += got.exchange_rejected;
      windows_closed += got.command_window;

      if (predicted_reports.size() == 0) begin
         if (error_count < 10)
            $display("%0t: unexpected result transaction: %s", $time, show(got));
         error_count++;
         return;
      end

      want = predicted_reports.pop_front();
      diff = "";
      if (got.exchange_valid !== want.exchange_valid) diff = {diff, " exchange_valid"};
      if (got.exchange_rejected !== want.exchange_rejected) diff = {diff, " exchange_rejected"};
      if (got.command_window !== want.command_window) diff = {diff, " command_window"};
      if (got.set_value !== want.set_value) diff = {diff, " set_value"};
      if (got.run_state !== want.run_state) diff = {diff, " run_state"};
      if (got.active_error !== want.active_error) diff = {diff, " active_error"};
      if (got.fault_code !== want.fault_code) diff = {diff, " fault_code"};
      if (got.power_on !== want.power_on) diff = {diff, " power_on"};
      if (got.pump_rate !== want.pump_rate) diff = {diff, " pump_rate"};
      if (got.blower_speed !== want.blower_speed) diff = {diff, " blower_speed"};
      if (got.combustion_temp !== want.combustion_temp) diff = {diff, " combustion_temp"};

      if (diff != "") begin
         if (error_count < 10) begin
            $display("%0t: result fields differ:%s", $time, diff);
            $display("   expected %s", show(want));
            $display("   actual   %s", show(got));
         end
         error_count++;
      end
   endtask

   // Sample all ports at the rising edge.
   always @(posedge clock) begin
      if (reset) begin
         gap_limit = IDLE_GAP_RESET;
         hunting_sync = 1'b0;
         in_frame = 1'b0;
         frame_pos = '0;
         crc_acc = CRC_INIT;
         half1_good = 1'b0;
         fixed_good = 1'b0;
         set_byte = '0;
         state_byte = '0;
         pump_byte = '0;
         fan_word = '0;
         chamber_word = '0;
         active_err_byte = '0;
         fault_byte = '0;
         held_state = '0;
         win_open = 1'b0;
         win_cnt = '0;
         predicted_reports.delete();
         error_count = 0;
         good_exchanges = 0;
         rejected_exchanges = 0;
         windows_closed = 0;
      end else begin
         if (csr_wr_en) gap_limit = csr_wr_data;
         if (req_tvalid && req_tready) parse_rx_byte(req_tdata[7:0], req_tdata[23:8]);
         if (rsp_tvalid && rsp_tready) check_report();
      end
      reports_due <= predicted_reports.size();
   end

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Heater exchange frame parser testbench
// Streams well-formed, damaged and cut exchanges mixed with line noise through
// the parser under several idle-gap settings, with random gaps on both sides
// and a long result stall, while the checker predicts every result.
// ----------------------------------------------------------------------------
module tb_top;
   import hefp_pkg::*;

   typedef enum {FLAW_NONE, FLAW_BIT, FLAW_FIXED, FLAW_CUT} flaw_type;

   localparam int PHASES = 6;
   localparam int PHASE_BYTES = 215;
   localparam int HOLD_CYCLES = 300;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // rx_byte[7:0], gap_ms[23:8]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;        // set_value[7:0] .. combustion_temp[68:53]
   logic [2:0]  rsp_tuser;        // exchange_valid[0], exchange_rejected[1], command_window[2]

   int error_count;
   int reports_due;
   int good_exchanges;
   int rejected_exchanges;
   int windows_closed;

   // Stimulus controls; recv_idle_max and hold_request are shared with the receiver process.
   logic [15:0] gap_limit_tb = IDLE_GAP_RESET;
   int          send_idle_max = 16;
   int          recv_idle_max = 16;
   bit          hold_request = 1'b0;
   bit          need_break = 1'b0;
   int          sent_bytes = 0;
   logic [7:0]  frame_buf [0:47];

   heater_exchange_frame_parser_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   hefp_checker checker_inst (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_tvalid         (req_tvalid),
      .req_tready         (req_tready),
      .req_tdata          (req_tdata),
      .rsp_tvalid         (rsp_tvalid),
      .rsp_tready         (rsp_tready),
      .rsp_tdata          (rsp_tdata),
      .rsp_tuser          (rsp_tuser),
      .error_count        (error_count),
      .reports_due        (reports_due),
      .good_exchanges     (good_exchanges),
      .rejected_exchanges (rejected_exchanges),
      .windows_closed     (windows_closed)
   );

   // 4 ns clock.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Gap that keeps the current exchange going.
   function automatic logic [15:0] short_gap();
      case ($urandom_range(0, 3))
         0: return 16'd0;
         1: return gap_limit_tb;
         default: return 16'($urandom_range(0, gap_limit_tb));
      endcase
   endfunction

   // Gap that starts a new exchange; only valid below the top threshold.
   function automatic logic [15:0] long_gap();
      case ($urandom_range(0, 3))
         0: return gap_limit_tb + 16'd1;
         1: return 16'hFFFF;
         default: return 16'($urandom_range(32'(gap_limit_tb) + 1, 65535));
      endcase
   endfunction

   // Modbus CRC-16 over the 22 data bytes of one half of frame_buf.
   function automatic logic [15:0] half_crc(input int first);
      logic [15:0] c;
      c = CRC_INIT;
      for (int k = first; k < first + int'(CRC_SPAN); k++) begin
         c = c ^ {8'h00, frame_buf[k]};
         repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   // Offers one byte transaction and waits until it is accepted.
   task automatic push_byte(input logic [7:0] d, input logic [15:0] gap);
      int idle;
      idle = $urandom_range(0, send_idle_max);
      if (idle > 0) begin
         req_tvalid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {gap, d};
      do @(posedge clock); while (!req_tready);
      sent_bytes++;
   endtask

   // Stops offering bytes and waits until every predicted result has come back.
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      wait (reports_due == 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_gap_limit(input logic [15:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      gap_limit_tb = value;
   endtask

   // Builds one 48-byte exchange with random telemetry, optionally damaged, and sends it.
   task automatic send_frame(input bit long_start, input flaw_type flaw);
      logic [15:0] c;
      int          len;
      int          pos;
      foreach (frame_buf[k]) frame_buf[k] = 8'($urandom);
      frame_buf[0] = $urandom_range(0, 1) ? HDR_CTRL : HDR_ALT;
      frame_buf[1] = SYNC_BYTE;
      frame_buf[OFS_HDR2] = HDR_CTRL;
      frame_buf[OFS_SYNC2] = SYNC_BYTE;
      frame_buf[OFS_FIXED_A] = FIXED_A_VAL;
      frame_buf[OFS_FIXED_B] = FIXED_B_VAL;
      // Mostly documented run states, sometimes a raw random byte that may lie above the last one.
      frame_buf[OFS_RUN_STATE] = ($urandom_range(0, 5) == 0) ? 8'($urandom) :
                                 8'($urandom_range(0, 8));

      // A wrong fixed byte under a good CRC fails only the fixed-byte check.
      if (flaw == FLAW_FIXED) begin
         case ($urandom_range(0, 3))
            0: pos = int'(OFS_HDR2);
            1: pos = int'(OFS_SYNC2);
            2: pos = int'(OFS_FIXED_A);
            default: pos = int'(OFS_FIXED_B);
         endcase
         frame_buf[pos] = frame_buf[pos] ^ 8'($urandom_range(1, 255));
      end

      c = half_crc(0);
      frame_buf[CRC1_HI_IDX] = c[15:8];
      frame_buf[CRC1_LO_IDX] = c[7:0];
      c = half_crc(24);
      frame_buf[CRC2_HI_IDX] = c[15:8];
      frame_buf[CRC2_HI_IDX + 1] = c[7:0];

      if (flaw == FLAW_BIT) begin
         pos = $urandom_range(2, 47);
         frame_buf[pos] = frame_buf[pos] ^ (8'd1 << $urandom_range(0, 7));
      end

      len = (flaw == FLAW_CUT) ? $urandom_range(3, 46) : 48;
      for (int k = 0; k < len; k++)
         push_byte(frame_buf[k],
                   (k == 0 && long_start && gap_limit_tb != 16'hFFFF) ? long_gap() : short_gap());
      need_break = (flaw == FLAW_CUT);
   endtask

   // Receiver: random stall before each result, and a long hold-off on request.
   initial begin : result_side
      int n;
      forever begin
         if (hold_request) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end else begin
            n = $urandom_range(0, recv_idle_max);
            if (n > 0) begin
               rsp_tready <= 1'b0;
               repeat (n) @(posedge clock);
            end
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Run limit, far above the slowest correct run.
   initial begin
      #4_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   // Stimulus and verdict.
   initial begin : byte_side
      int          start_count;
      int          sel;
      int          n;
      logic [15:0] limit_value;
      flaw_type    flaw;
      bit          pressure_done;
      pressure_done = 1'b0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed bytes: gap extremes, threshold boundary, header retry and a
      // header that arrives right after a long gap.
      push_byte(8'h00, 16'h0000);
      push_byte(8'hFF, 16'hFFFF);
      push_byte(HDR_CTRL, IDLE_GAP_RESET);
      push_byte(8'h12, 16'h0000);
      push_byte(SYNC_BYTE, 16'h0000);
      push_byte(HDR_ALT, 16'h0001);
      push_byte(HDR_CTRL, 16'h0002);
      push_byte(SYNC_BYTE, 16'h0003);
      push_byte(8'h55, 16'h5555);
      push_byte(8'hAA, 16'hAAAA);
      push_byte(HDR_ALT, IDLE_GAP_RESET + 16'd1);
      push_byte(SYNC_BYTE, 16'h0000);
      need_break = 1'b1;

      for (int ph = 0; ph < PHASES; ph++) begin
         // New threshold only once the parser has gone quiet.
         if (ph > 0) begin
            settle();
            case (ph)
               1: limit_value = 16'd0;
               2: limit_value = 16'($urandom_range(1, 65534));
               3: limit_value = 16'hFFFF;
               4: limit_value = IDLE_GAP_RESET;
               default: limit_value = 16'($urandom_range(1, 2000));
            endcase
            write_gap_limit(limit_value);
         end

         start_count = sent_bytes;
         while (sent_bytes - start_count < PHASE_BYTES) begin
            send_idle_max = ($urandom_range(0, 4) == 0) ? 0 : 16;
            recv_idle_max = ($urandom_range(0, 4) == 0) ? 0 : 16;

            // Long result stall while bytes keep coming back to back.
            if (ph == 2 && !pressure_done) begin
               pressure_done = 1'b1;
               hold_request = 1'b1;
               send_idle_max = 0;
               repeat (4) send_frame(1'b1, FLAW_NONE);
               settle();
               continue;
            end

            // A little line noise between exchanges.
            n = $urandom_range(0, 2);
            repeat (n)
               push_byte(8'($urandom),
                         ($urandom_range(0, 9) == 0 && gap_limit_tb != 16'hFFFF) ?
                         long_gap() : short_gap());

            sel = $urandom_range(0, 99);
            if (sel >= 96) begin
               // Command window over noise, with no exchange in it.
               push_byte(8'($urandom),
                         (gap_limit_tb != 16'hFFFF) ? long_gap() : short_gap());
               repeat ($urandom_range(20, 60)) push_byte(8'($urandom), short_gap());
            end else begin
               if (sel < 65) flaw = FLAW_NONE;
               else if (sel < 78) flaw = FLAW_BIT;
               else if (sel < 88) flaw = FLAW_FIXED;
               else if (gap_limit_tb != 16'hFFFF) flaw = FLAW_CUT;
               else flaw = FLAW_NONE;
               send_frame(need_break || $urandom_range(0, 1), flaw);
            end
         end

         // Never leave a cut exchange open into the next threshold.
         if (need_break) send_frame(1'b1, FLAW_NONE);
      end

      settle();
      $display("Sent %0d bytes under %0d idle-gap thresholds with random gaps and stalls.",
               sent_bytes, PHASES);
      $display("Returned %0d good exchanges, %0d rejected, %0d command windows.",
               good_exchanges, rejected_exchanges, windows_closed);
      if (error_count == 0 && reports_due == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

### sim.f
hdl/hefp_pkg.sv
hdl/hefp_in_reg.sv
hdl/hefp_core.sv
hdl/hefp_out_reg.sv
hdl/heater_exchange_frame_parser_unit.sv
test/hefp_checker.sv
test/tb_top.sv
